// ----- src/sbe_pkg.sv -----
package sbe_pkg;

    typedef enum logic [2:0] {
        OP_CONST  = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_OUT    = 3'd5,
        OP_RET    = 3'd6,
        OP_BAD    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_RUNNING   = 3'd0,
        ST_DONE      = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_BADOP     = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_UNDERFLOW = 3'd5,
        ST_IGNORED   = 3'd6
    } status_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] immediate;
        logic               first_of_program;
        logic               last_of_program;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] print_value;
        logic               print_valid;
        logic [2:0]         status;
        logic               run_ended;
    } out_word_t;

    typedef struct packed {
        logic    load_in;
        logic    push;
        logic    rd_top;
        logic    rd_second;
        logic    cap_b;
        logic    cap_a;
        logic    prep;
        logic    pop_two;
        logic    pop_print;
        logic    mul;
        logic    mul_sat;
        logic    div_start;
        logic    div_sat;
        logic    write_res;
        logic    emit;
        logic    set_status;
        status_t status_code;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic ignore;
        logic full;
        logic lt2;
        logic empty;
        logic b_zero;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic [31:0] q_mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] q_sat_mag(input logic [47:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (mag > 48'h0000_8000_0000) begin
                r = 32'h8000_0000;
            end else begin
                r = ~mag[31:0] + 32'd1;
            end
        end else begin
            if (mag > 48'h0000_7FFF_FFFF) begin
                r = 32'h7FFF_FFFF;
            end else begin
                r = mag[31:0];
            end
        end
        return r;
    endfunction

endpackage

// ----- src/sbe_ram.sv -----
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sbe_div.sv -----
module sbe_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num_mag,
    input  logic [31:0] den_mag,
    output logic        busy,
    output logic        ovf,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic        ovf_reg;
    logic [4:0]  count_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;
    logic        too_big;

    assign trial   = {rem_reg, quo_reg[31]};
    assign diff    = trial - {1'b0, den_mag};
    assign fits    = trial >= {1'b0, den_mag};
    assign too_big = {16'd0, num_mag[31:16]} >= den_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else if (start) begin
            busy_reg <= !too_big;
            ovf_reg  <= too_big;
        end else if (busy_reg && count_reg == 5'd0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            count_reg <= 5'd31;
            rem_reg   <= {16'd0, num_mag[31:16]};
            quo_reg   <= {num_mag[15:0], 16'd0};
        end else if (busy_reg) begin
            count_reg <= count_reg - 5'd1;
            rem_reg   <= fits ? diff[31:0] : trial[31:0];
            quo_reg   <= {quo_reg[30:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign ovf      = ovf_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/sbe_dpath.sv -----
module sbe_dpath #(
    parameter int STACK_DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbe_pkg::cmd_t     cmd,
    output sbe_pkg::stat_t    stat,
    input  sbe_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sbe_pkg::out_word_t m_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    sbe_pkg::in_word_t  in_reg;
    sbe_pkg::out_word_t m_data_reg;
    sbe_pkg::status_t   status_reg;
    sbe_pkg::status_t   final_status;
    logic               m_valid_reg;
    logic [SPW-1:0]     sp_reg;
    logic               halted_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [31:0]        mag_a_reg;
    logic [31:0]        mag_b_reg;
    logic               neg_reg;
    logic [31:0]        res_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        pval_reg;
    logic               pvalid_reg;
    logic [SPW-1:0]     sp_m1;
    logic [SPW-1:0]     sp_m2;
    logic [32:0]        addsub;
    logic               halted_eff;
    logic               ended;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic               div_busy;
    logic               div_ovf;
    logic [31:0]        div_quo;
    logic [47:0]        div_mag;

    assign sp_m1      = sp_reg - SPW'(1);
    assign sp_m2      = sp_reg - SPW'(2);
    assign halted_eff = halted_reg & ~in_reg.first_of_program;

    assign ram_we    = cmd.push | cmd.write_res;
    assign ram_waddr = cmd.push ? sp_reg[AW-1:0] : sp_m2[AW-1:0];
    assign ram_wdata = cmd.push ? in_reg.immediate : res_reg;
    assign ram_re    = cmd.rd_top | cmd.rd_second;
    assign ram_raddr = cmd.rd_top ? sp_m1[AW-1:0] : sp_m2[AW-1:0];

    sbe_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sbe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_mag (mag_a_reg),
        .den_mag (mag_b_reg),
        .busy    (div_busy),
        .ovf     (div_ovf),
        .quotient(div_quo)
    );

    assign addsub = (sbe_pkg::op_t'(in_reg.op) == sbe_pkg::OP_SUB)
                  ? ({a_reg[31], a_reg} - {b_reg[31], b_reg})
                  : ({a_reg[31], a_reg} + {b_reg[31], b_reg});
    assign div_mag = div_ovf ? 48'hFFFF_FFFF_FFFF : {16'd0, div_quo};

    always_comb begin
        final_status = status_reg;
        if (status_reg == sbe_pkg::ST_RUNNING && in_reg.last_of_program) begin
            final_status = sbe_pkg::ST_DONE;
        end
    end

    assign ended = (final_status != sbe_pkg::ST_RUNNING) &&
                   (final_status != sbe_pkg::ST_IGNORED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                sp_reg <= sp_reg + SPW'(1);
            end else if (cmd.write_res || cmd.pop_print) begin
                sp_reg <= sp_m1;
            end else if (cmd.pop_two) begin
                sp_reg <= sp_m2;
            end
            if (cmd.emit) begin
                halted_reg  <= halted_eff | ended;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg     <= s_data;
            status_reg <= sbe_pkg::ST_RUNNING;
            pval_reg   <= '0;
            pvalid_reg <= 1'b0;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.pop_print) begin
            pval_reg   <= ram_rdata;
            pvalid_reg <= 1'b1;
        end
        if (cmd.cap_b) begin
            b_reg <= ram_rdata;
        end
        if (cmd.cap_a) begin
            a_reg <= ram_rdata;
        end
        if (cmd.prep) begin
            mag_a_reg <= sbe_pkg::q_mag(a_reg);
            mag_b_reg <= sbe_pkg::q_mag(b_reg);
            neg_reg   <= a_reg[31] ^ b_reg[31];
            if (addsub[32] != addsub[31]) begin
                res_reg <= addsub[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                res_reg <= addsub[31:0];
            end
        end
        if (cmd.mul) begin
            prod_reg <= mag_a_reg * mag_b_reg;
        end
        if (cmd.mul_sat) begin
            res_reg <= sbe_pkg::q_sat_mag(prod_reg[63:16], neg_reg);
        end
        if (cmd.div_sat) begin
            res_reg <= sbe_pkg::q_sat_mag(div_mag, neg_reg);
        end
        if (cmd.emit) begin
            m_data_reg.print_value <= pval_reg;
            m_data_reg.print_valid <= pvalid_reg;
            m_data_reg.status      <= final_status;
            m_data_reg.run_ended   <= ended;
        end
    end

    assign stat.op       = sbe_pkg::op_t'(in_reg.op);
    assign stat.ignore   = halted_eff;
    assign stat.full     = sp_reg == SPW'(STACK_DEPTH);
    assign stat.lt2      = sp_reg < SPW'(2);
    assign stat.empty    = sp_reg == '0;
    assign stat.b_zero   = b_reg == '0;
    assign stat.div_done = !div_busy;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> sp_reg < SPW'(STACK_DEPTH))
        else $error("push into full stack");

    a_write_two: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_res |-> sp_reg >= SPW'(2))
        else $error("result write with fewer than two entries");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("emitted word not presented");

endmodule

// ----- src/sbe_ctrl.sv -----
module sbe_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sbe_pkg::stat_t stat,
    output sbe_pkg::cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_READ_B   = 11'b000_0000_0100,
        S_READ_A   = 11'b000_0000_1000,
        S_OPER     = 11'b000_0001_0000,
        S_MUL      = 11'b000_0010_0000,
        S_MUL_SAT  = 11'b000_0100_0000,
        S_DIV      = 11'b000_1000_0000,
        S_DIV_WAIT = 11'b001_0000_0000,
        S_WRITE    = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd             = '0;
        cmd.status_code = sbe_pkg::ST_RUNNING;
        state_next      = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                if (stat.ignore) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sbe_pkg::ST_IGNORED;
                end else begin
                    unique case (stat.op) inside
                        sbe_pkg::OP_CONST: begin
                            if (stat.full) begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = sbe_pkg::ST_OVERFLOW;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL,
                        sbe_pkg::OP_DIV: begin
                            if (stat.lt2) begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = sbe_pkg::ST_UNDERFLOW;
                            end else begin
                                cmd.rd_top = 1'b1;
                                state_next = S_READ_B;
                            end
                        end
                        sbe_pkg::OP_OUT: begin
                            if (stat.empty) begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = sbe_pkg::ST_UNDERFLOW;
                            end else begin
                                cmd.rd_top = 1'b1;
                                state_next = S_READ_B;
                            end
                        end
                        sbe_pkg::OP_RET: begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sbe_pkg::ST_DONE;
                        end
                        default: begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = sbe_pkg::ST_BADOP;
                        end
                    endcase
                end
            end
            S_READ_B: begin
                if (stat.op == sbe_pkg::OP_OUT) begin
                    cmd.pop_print = 1'b1;
                    state_next    = S_FINISH;
                end else begin
                    cmd.cap_b     = 1'b1;
                    cmd.rd_second = 1'b1;
                    state_next    = S_READ_A;
                end
            end
            S_READ_A: begin
                cmd.cap_a  = 1'b1;
                state_next = S_OPER;
            end
            S_OPER: begin
                cmd.prep = 1'b1;
                if (stat.op == sbe_pkg::OP_DIV && stat.b_zero) begin
                    cmd.pop_two     = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = sbe_pkg::ST_DIVZERO;
                    state_next      = S_FINISH;
                end else if (stat.op == sbe_pkg::OP_MUL) begin
                    state_next = S_MUL;
                end else if (stat.op == sbe_pkg::OP_DIV) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_MUL_SAT;
            end
            S_MUL_SAT: begin
                cmd.mul_sat = 1'b1;
                state_next  = S_WRITE;
            end
            S_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.div_sat = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.write_res = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

// ----- src/stack_bytecode_executor_unit.sv -----
// Channel   Ports                      Word
// input     s_valid s_ready s_data     op, immediate, first_of_program, last_of_program
// result    m_valid m_ready m_data     print_value, print_valid, status, run_ended
//
// One word at a time: the next word is accepted only after the result of the last has
// been handed to the output register. Division uses the radix-2 divider, which retires
// one quotient bit per cycle over 32 steps and is skipped on quotient overflow. The
// result is presented as the controller returns to idle, ahead of the next accept.
// Reset (aresetn low, synchronous) clears the stack pointer, halted flag, controller
// and output valid; the stack contents are kept.
// A result waiting in the output register holds while the next word is accepted;
// the next result holds in the datapath until the output register frees up.
module stack_bytecode_executor_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sbe_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sbe_pkg::out_word_t m_data
);

    sbe_pkg::cmd_t  cmd;
    sbe_pkg::stat_t stat;

    sbe_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    sbe_dpath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dpath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .stat   (stat),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

// ----- sim/stack_bytecode_executor_unit_checker.sv -----
`timescale 1ns / 1ps

module stack_bytecode_executor_unit_checker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  sbe_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  sbe_pkg::out_word_t m_data,
    output int                 mismatches,
    output int                 outstanding
);

    logic [31:0]        value_mem [STACK_DEPTH];
    int unsigned        level = 0;
    bit                 stopped = 1'b0;
    sbe_pkg::out_word_t pending_results [$];
    int                 fail_total = 0;
    int                 queued = 0;

    assign mismatches  = fail_total;
    assign outstanding = queued;

    function automatic longint q_val(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [63:0] q_abs(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [31:0] q_clamp(longint x);
        if (x > 64'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        if (x < -64'sh8000_0000) begin
            return 32'h8000_0000;
        end
        return 32'(x);
    endfunction

    function automatic sbe_pkg::out_word_t execute_word(sbe_pkg::in_word_t w);
        sbe_pkg::out_word_t r;
        sbe_pkg::status_t   st;
        longint             a;
        longint             b;
        longint             res;
        logic [63:0]        mag;
        bit                 neg;
        r  = '0;
        st = sbe_pkg::ST_RUNNING;
        if (w.first_of_program) begin
            stopped = 1'b0;
        end
        if (stopped) begin
            st = sbe_pkg::ST_IGNORED;
        end else begin
            case (sbe_pkg::op_t'(w.op))
                sbe_pkg::OP_CONST: begin
                    if (level >= STACK_DEPTH) begin
                        st = sbe_pkg::ST_OVERFLOW;
                    end else begin
                        value_mem[level] = w.immediate;
                        level++;
                    end
                end
                sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV: begin
                    if (level < 2) begin
                        st = sbe_pkg::ST_UNDERFLOW;
                    end else begin
                        a   = q_val(value_mem[level - 2]);
                        b   = q_val(value_mem[level - 1]);
                        neg = (a < 0) != (b < 0);
                        if (sbe_pkg::op_t'(w.op) == sbe_pkg::OP_DIV && b == 0) begin
                            level -= 2;
                            st = sbe_pkg::ST_DIVZERO;
                        end else begin
                            case (sbe_pkg::op_t'(w.op))
                                sbe_pkg::OP_ADD: res = a + b;
                                sbe_pkg::OP_SUB: res = a - b;
                                sbe_pkg::OP_MUL: begin
                                    mag = (q_abs(a) * q_abs(b)) >> 16;
                                    res = neg ? -longint'(mag) : longint'(mag);
                                end
                                default: begin
                                    mag = (q_abs(a) << 16) / q_abs(b);
                                    res = neg ? -longint'(mag) : longint'(mag);
                                end
                            endcase
                            level--;
                            value_mem[level - 1] = q_clamp(res);
                        end
                    end
                end
                sbe_pkg::OP_OUT: begin
                    if (level == 0) begin
                        st = sbe_pkg::ST_UNDERFLOW;
                    end else begin
                        level--;
                        r.print_value = value_mem[level];
                        r.print_valid = 1'b1;
                    end
                end
                sbe_pkg::OP_RET: st = sbe_pkg::ST_DONE;
                default:         st = sbe_pkg::ST_BADOP;
            endcase
            if (st == sbe_pkg::ST_RUNNING && w.last_of_program) begin
                st = sbe_pkg::ST_DONE;
            end
            if (st != sbe_pkg::ST_RUNNING) begin
                r.run_ended = 1'b1;
                stopped     = 1'b1;
            end
        end
        r.status = st;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin
        sbe_pkg::out_word_t got;
        sbe_pkg::out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: %h", got);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("print_value", want.print_value, got.print_value);
                    check_field("print_valid", want.print_valid, got.print_valid);
                    check_field("status", want.status, got.status);
                    check_field("run_ended", want.run_ended, got.run_ended);
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(execute_word(s_data));
            end
            queued <= pending_results.size();
        end
    end

endmodule

// ----- sim/stack_bytecode_executor_unit_tb.sv -----
`timescale 1ns / 1ps

module stack_bytecode_executor_unit_tb;

    localparam int STACK_DEPTH   = 256;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PROGRAM_WORDS = 450;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ZERO = 32'h0000_0000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    sbe_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    sbe_pkg::out_word_t m_data;
    int                 phase = 0;
    int                 program_words = 0;
    int                 mismatches;
    int                 outstanding;

    always #2 aclk = ~aclk;

    stack_bytecode_executor_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    stack_bytecode_executor_unit_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic sbe_pkg::in_word_t make_word(sbe_pkg::op_t op, logic [31:0] imm,
                                                    logic first, logic last);
        sbe_pkg::in_word_t w;
        w.op               = op;
        w.immediate        = imm;
        w.first_of_program = first;
        w.last_of_program  = last;
        return w;
    endfunction

    function automatic logic [31:0] pick_immediate();
        logic [31:0] mag;
        mag = $urandom_range(32'h0008_0000, 0);
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return Q_ZERO;
            3, 4, 5: return $urandom_range(1) ? -mag : mag;
            default: return $urandom();
        endcase
    endfunction

    function automatic sbe_pkg::op_t pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 46) return sbe_pkg::OP_CONST;
        if (r < 55) return sbe_pkg::OP_ADD;
        if (r < 63) return sbe_pkg::OP_SUB;
        if (r < 71) return sbe_pkg::OP_MUL;
        if (r < 79) return sbe_pkg::OP_DIV;
        if (r < 93) return sbe_pkg::OP_OUT;
        if (r < 97) return sbe_pkg::OP_RET;
        return sbe_pkg::OP_BAD;
    endfunction

    task automatic send_word(sbe_pkg::in_word_t w);
        int idle_pct;
        idle_pct = (phase == 0) ? 25 : (phase == 1) ? 54 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic run_program();
        int   len;
        logic first;
        logic last;
        len = $urandom_range(14, 1);
        for (int i = 0; i < len; i++) begin
            first = (i == 0) || ($urandom_range(99) < 3);
            last  = (i == len - 1) && ($urandom_range(99) < 80);
            send_word(make_word(pick_op(), pick_immediate(), first, last));
        end
        program_words += len;
        // trailing words without a program start, mostly ignored
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 1)) begin
                send_word(make_word(pick_op(), pick_immediate(), 1'b0,
                                    1'($urandom_range(1))));
            end
        end
    endtask

    initial begin
        int  hold_left;
        bit  held_once;
        hold_left = 0;
        held_once = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase == 2 && !held_once) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= ((phase == 0) ? 54 : (phase == 1) ? 25 : 0));
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** stack_bytecode_executor_unit: FAILED **");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(make_word(sbe_pkg::OP_CONST, Q_MAX,         1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, Q_MAX,         1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_ADD,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, Q_MIN,         1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_SUB,   Q_MAX,         1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, Q_MIN,         1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_MUL,   Q_MIN,         1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, 32'h0002_0000, 1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_DIV,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_DIV,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_OUT,   Q_ZERO,        1'b0, 1'b1));
        send_word(make_word(sbe_pkg::OP_OUT,   Q_ZERO,        1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_ADD,   Q_ZERO,        1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_BAD,   Q_MAX,         1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, 32'hFFFF_0000, 1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, 32'h0003_0000, 1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_MUL,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, 32'h0000_8000, 1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_DIV,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_OUT,   Q_ZERO,        1'b0, 1'b1));
        send_word(make_word(sbe_pkg::OP_RET,   Q_ZERO,        1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, Q_MIN,         1'b1, 1'b1));
        send_word(make_word(sbe_pkg::OP_CONST, 32'h0000_0001, 1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_SUB,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_OUT,   Q_ZERO,        1'b0, 1'b1));
        send_word(make_word(sbe_pkg::OP_CONST, Q_MIN,         1'b1, 1'b0));
        send_word(make_word(sbe_pkg::OP_CONST, 32'hFFFF_0000, 1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_DIV,   Q_ZERO,        1'b0, 1'b0));
        send_word(make_word(sbe_pkg::OP_OUT,   Q_ZERO,        1'b0, 1'b1));
        send_word(make_word(sbe_pkg::OP_BAD,   Q_ZERO,        1'b1, 1'b1));

        // fill the empty stack, then push once more
        for (int i = 0; i <= STACK_DEPTH; i++) begin
            send_word(make_word(sbe_pkg::OP_CONST, pick_immediate(), i == 0, 1'b0));
        end

        while (program_words < PROGRAM_WORDS) begin
            if (program_words >= 300 && phase != 2) begin
                phase <= 2;
            end else if (program_words >= 150 && phase == 0) begin
                phase <= 1;
            end
            run_program();
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** stack_bytecode_executor_unit: PASSED **");
        end else begin
            $display("** stack_bytecode_executor_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/sbe_pkg.sv
src/sbe_ram.sv
src/sbe_div.sv
src/sbe_dpath.sv
src/sbe_ctrl.sv
src/stack_bytecode_executor_unit.sv
sim/stack_bytecode_executor_unit_checker.sv
sim/stack_bytecode_executor_unit_tb.sv
